>>> src/prf_pkg.sv
// prf_pkg: shared constants, types and the colour table for the packed pixel frame store.
// Used by the top level, prf_front, prf_queue and prf_back; depends on nothing.

package prf_pkg;

	localparam int COLUMNS     = 240;
	localparam int ROWS        = 400;
	localparam int COL_BYTES   = (ROWS + 1) / 2;
	localparam int FRAME_BYTES = COL_BYTES + 4;
	localparam int STORE_DEPTH = COLUMNS * COL_BYTES;

	localparam int ADDR_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int ROWB_W   = (COL_BYTES > 1) ? $clog2(COL_BYTES) : 1;
	localparam int COLCNT_W = $clog2(COLUMNS + 1);
	localparam int MUL_W    = ADDR_W + 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] MODE_BYTE = 8'h90;

	typedef enum logic [1:0] {
		OP_PIXEL = 2'd0,
		OP_FILL  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CMD_RESULT,
		CMD_PIXEL,
		CMD_FILL,
		CMD_READ
	} cmd_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FILL,
		BK_READ
	} back_state_t;

	// classified command handed from front to back
	typedef struct packed {
		cmd_kind_t             kind;
		logic                  status;
		logic [7:0]            data;
		logic [ADDR_W-1:0]     addr;
		logic [3:0]            nib;
		logic                  odd;
		logic                  last_even;
		logic [ROWB_W-1:0]     span;
		logic [COLCNT_W-1:0]   cols;
	} cmd_t;

	function automatic logic [3:0] nibble_of(input logic [2:0] code);
		logic [3:0] n;
		unique case (code)
			3'd0: n = 4'h0;
			3'd1: n = 4'h2;
			3'd2: n = 4'h4;
			3'd3: n = 4'h8;
			3'd4: n = 4'h6;
			3'd5: n = 4'hC;
			3'd6: n = 4'hA;
			3'd7: n = 4'hE;
			default: n = 4'h0;
		endcase
		return n;
	endfunction

endpackage

>>> src/packed_pixel_rect_fill_top.sv
// packed_pixel_rect_fill_top: 4-bit-per-pixel frame store with pixel set, rectangle fill
// and transmit-frame byte read. Depends on prf_pkg, prf_front, prf_queue, prf_back.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-----------------------------------------------
//   command   | start / busy       | opcode column row rect_width rect_height
//             |                    | colour frame_line frame_offset
//   result    | done (1-cycle)     | status read_data
//
// Flow: a command is held in the input register, where it is classified (bounds
// check, column*bytes-per-column address multiply) and written into the queue. With the
// queue empty and the back end idle, a set pixel or a command answered without the memory
// passes the input register, the queue and the back end's registered done; a frame-byte
// read from the column body also passes the registered memory read (BK_READ). A fill holds
// the back end for rect_width columns of the bytes spanned by the rows, one byte per cycle
// through the single memory port, and its done follows the last write.
// Reset: arst_n clears the control path only; the frame memory is undefined until written.
// Stalls: busy rises when the input register holds a command and the two-entry queue is
// full; the result side has no backpressure, so done is a plain one-cycle strobe.

module packed_pixel_rect_fill_top import prf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] opcode,
	input  logic [8:0] column,
	input  logic [8:0] row,
	input  logic [8:0] rect_width,
	input  logic [8:0] rect_height,
	input  logic [7:0] colour,
	input  logic [7:0] frame_line,
	input  logic [7:0] frame_offset,
	output logic       done,
	output logic       status,
	output logic [7:0] read_data
);

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	cmd_t front_cmd;
	cmd_t head_cmd;

	// front: takes commands, checks ranges, forms byte addresses
	prf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.column       (column),
		.row          (row),
		.rect_width   (rect_width),
		.rect_height  (rect_height),
		.colour       (colour),
		.frame_line   (frame_line),
		.frame_offset (frame_offset),
		.q_full       (q_full),
		.push         (q_push),
		.cmd          (front_cmd)
	);

	// queue lets the front keep taking commands while a long fill runs
	prf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (front_cmd),
		.pop      (q_pop),
		.head     (head_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	// back: owns the frame memory and the result register
	prf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_cmd),
		.empty     (q_empty),
		.pop       (q_pop),
		.done      (done),
		.status    (status),
		.read_data (read_data)
	);

endmodule

>>> src/prf_front.sv
// prf_front: input register and command classifier (range checks, address multiply).
// Depends on prf_pkg.

module prf_front import prf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [8:0]  column,
	input  logic [8:0]  row,
	input  logic [8:0]  rect_width,
	input  logic [8:0]  rect_height,
	input  logic [7:0]  colour,
	input  logic [7:0]  frame_line,
	input  logic [7:0]  frame_offset,
	input  logic        q_full,
	output logic        push,
	output cmd_t        cmd
);

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [8:0]  col_s1;
	logic [8:0]  row_s1;
	logic [8:0]  w_s1;
	logic [8:0]  h_s1;
	logic [2:0]  colour_s1;
	logic [7:0]  line_s1;
	logic [7:0]  off_s1;

	logic             accept;
	logic [9:0]       col_end;
	logic [9:0]       row_end;
	logic [9:0]       last_row;
	logic             pix_ok;
	logic             fill_ok;
	logic             fill_empty;
	logic             rd_ok;
	logic [8:0]       mul_sel;
	logic [MUL_W-1:0] row_byte;
	logic [MUL_W-1:0] prod;
	logic [MUL_W-1:0] addr_full;

	assign busy   = valid_s1 & q_full;
	assign accept = start & ~busy;
	assign push   = valid_s1 & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= opcode;
			col_s1    <= column;
			row_s1    <= row;
			w_s1      <= rect_width;
			h_s1      <= rect_height;
			colour_s1 <= colour[2:0];
			line_s1   <= frame_line;
			off_s1    <= frame_offset;
		end
	end

	always_comb begin
		col_end    = {1'b0, col_s1} + {1'b0, w_s1};
		row_end    = {1'b0, row_s1} + {1'b0, h_s1};
		last_row   = row_end - 10'd1;
		pix_ok     = ({1'b0, col_s1} < 10'(COLUMNS)) && ({1'b0, row_s1} < 10'(ROWS));
		fill_ok    = (col_end <= 10'(COLUMNS)) && (row_end <= 10'(ROWS));
		fill_empty = (w_s1 == 9'd0) || (h_s1 == 9'd0);
		rd_ok      = ({2'b0, line_s1} < 10'(COLUMNS)) && ({2'b0, off_s1} < 10'(FRAME_BYTES));

		// column base times bytes per column, plus byte within the column
		if (op_t'(op_s1) == OP_READ) begin
			mul_sel  = {1'b0, line_s1};
			row_byte = MUL_W'(off_s1) - MUL_W'(2);
		end else begin
			mul_sel  = col_s1;
			row_byte = MUL_W'(row_s1[8:1]);
		end
		prod      = MUL_W'(mul_sel) * MUL_W'(COL_BYTES);
		addr_full = prod + row_byte;

		cmd           = '0;
		cmd.kind      = CMD_RESULT;
		cmd.status    = 1'b1;
		cmd.addr      = addr_full[ADDR_W-1:0];
		cmd.nib       = nibble_of(colour_s1);
		cmd.odd       = row_s1[0];
		cmd.last_even = ~last_row[0];
		cmd.span      = ROWB_W'(last_row[8:1]) - ROWB_W'(row_s1[8:1]);
		cmd.cols      = COLCNT_W'(w_s1);

		unique case (op_t'(op_s1))
			OP_PIXEL: begin
				if (pix_ok) begin
					cmd.kind   = CMD_PIXEL;
					cmd.status = 1'b0;
				end
			end
			OP_FILL: begin
				if (fill_ok) begin
					cmd.status = 1'b0;
					if (!fill_empty) begin
						cmd.kind = CMD_FILL;
					end
				end
			end
			OP_READ: begin
				if (rd_ok) begin
					cmd.status = 1'b0;
					priority if (off_s1 == 8'd0) begin
						cmd.data = MODE_BYTE;
					end else if (off_s1 == 8'd1) begin
						cmd.data = line_s1;
					end else if ({2'b0, off_s1} < 10'(COL_BYTES + 2)) begin
						cmd.kind = CMD_READ;
					end else begin
						cmd.data = 8'h00;
					end
				end
			end
			OP_NONE: begin
				cmd.status = 1'b1;
			end
			default: begin
				cmd.status = 1'b1;
			end
		endcase
	end

endmodule

>>> src/prf_queue.sv
// prf_queue: short command queue decoupling the classifier from the executor.
// Depends on prf_pkg.

module prf_queue import prf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);

	cmd_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] n;
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + QPTR_W'(1);
		end
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> src/prf_back.sv
// prf_back: command executor with the nibble-addressable frame memory and result register.
// Depends on prf_pkg.

module prf_back import prf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       empty,
	output logic       pop,
	output logic       done,
	output logic       status,
	output logic [7:0] read_data
);

	// frame memory, split in high and low nibble lanes
	logic [3:0] mem_hi [STORE_DEPTH];
	logic [3:0] mem_lo [STORE_DEPTH];

	back_state_t state_q;
	back_state_t state_d;

	logic [ADDR_W-1:0]   base_q;
	logic [ROWB_W-1:0]   cnt_q;
	logic [ROWB_W-1:0]   span_q;
	logic [COLCNT_W-1:0] cols_q;
	logic                first_odd_q;
	logic                last_even_q;
	logic [3:0]          nib_q;
	logic [7:0]          rd_q;

	logic                done_q;
	logic                status_q;
	logic [7:0]          data_q;

	logic                we_hi;
	logic                we_lo;
	logic                re;
	logic [ADDR_W-1:0]   addr;
	logic [3:0]          wnib;
	logic                res_load;
	logic                res_status;
	logic [7:0]          res_data;
	logic                col_last;
	logic                fill_last;

	assign col_last  = (cnt_q == span_q);
	assign fill_last = col_last && (cols_q == COLCNT_W'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					unique case (head.kind)
						CMD_FILL: state_d = BK_FILL;
						CMD_READ: state_d = BK_READ;
						default:  state_d = BK_IDLE;
					endcase
				end
			end
			BK_FILL: begin
				if (fill_last) begin
					state_d = BK_IDLE;
				end
			end
			BK_READ: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		we_hi      = 1'b0;
		we_lo      = 1'b0;
		re         = 1'b0;
		addr       = head.addr;
		wnib       = head.nib;
		res_load   = 1'b0;
		res_status = 1'b0;
		res_data   = 8'h00;
		unique case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					unique case (head.kind)
						CMD_RESULT: begin
							res_load   = 1'b1;
							res_status = head.status;
							res_data   = head.data;
						end
						CMD_PIXEL: begin
							we_hi    = ~head.odd;
							we_lo    = head.odd;
							res_load = 1'b1;
						end
						CMD_READ: begin
							re = 1'b1;
						end
						CMD_FILL: begin
							pop = 1'b1;
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			BK_FILL: begin
				// partial nibbles only at an odd top row or an even bottom row
				addr     = base_q + ADDR_W'(cnt_q);
				wnib     = nib_q;
				we_hi    = ~((cnt_q == '0) && first_odd_q);
				we_lo    = ~(col_last && last_even_q);
				res_load = fill_last;
			end
			BK_READ: begin
				res_load = 1'b1;
				res_data = rd_q;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q <= res_status;
			data_q   <= res_data;
		end
		if (state_q == BK_IDLE && !empty && head.kind == CMD_FILL) begin
			base_q      <= head.addr;
			cnt_q       <= '0;
			span_q      <= head.span;
			cols_q      <= head.cols;
			first_odd_q <= head.odd;
			last_even_q <= head.last_even;
			nib_q       <= head.nib;
		end else if (state_q == BK_FILL) begin
			if (col_last) begin
				cnt_q  <= '0;
				base_q <= base_q + ADDR_W'(COL_BYTES);
				cols_q <= cols_q - COLCNT_W'(1);
			end else begin
				cnt_q <= cnt_q + ROWB_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we_hi) begin
			mem_hi[addr] <= wnib;
		end
		if (we_lo) begin
			mem_lo[addr] <= wnib;
		end
		if (re) begin
			rd_q <= {mem_hi[addr], mem_lo[addr]};
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign read_data = data_q;

endmodule

>>> src/prf_checker.sv
// prf_checker: port-level assertions for packed_pixel_rect_fill_top, bound to the top level.
// Depends on nothing but the top level's port names.

module prf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] opcode,
	input logic [8:0] column,
	input logic [8:0] row,
	input logic [8:0] rect_width,
	input logic [8:0] rect_height,
	input logic [7:0] colour,
	input logic [7:0] frame_line,
	input logic [7:0] frame_offset,
	input logic       done,
	input logic       status,
	input logic [7:0] read_data
);

	// a rejected transaction never carries data
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> read_data == 8'h00)
		else $error("rejected result with nonzero read_data");

	// busy can only rise right after an accepted transaction
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted transaction");

	// with nothing accepted, a free input stays free
	a_free_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> !busy)
		else $error("busy rose while idle");

endmodule

bind packed_pixel_rect_fill_top prf_checker u_prf_checker (.*);
